### hdl/dcs_pkg.sv
package dcs_pkg;

	localparam int CUR_W  = 13;
	localparam int CNT_W  = 6;
	localparam int PLUG_W = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic [CUR_W-1:0] cur_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD    = 2'd0,
		REG_STABLE_COUNT = 2'd1,
		REG_PENALTY      = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_FILL   = 1'b1
	} action_t;

	localparam cur_t THRESHOLD_RST    = 13'd100;
	localparam cnt_t STABLE_COUNT_RST = 6'd50;
	localparam cnt_t PENALTY_RST      = 6'd10;

endpackage

### hdl/demand_current_stabilizer_core.sv
// Each accepted transaction is registered in the working stage, and its result then in the result register.
// Throughput: one transaction per cycle; a held result stalls the input only once the
// single working stage is also full.
// Reset: all per-plug state clears and the control registers load their defaults at once;
// each ring reads as zero through its fill value and fill count, so no clearing pass is needed.
module demand_current_stabilizer_core
	import dcs_pkg::*;
#(
	parameter int SAMPLES = 8,
	parameter int PLUGS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic              action,
	input  logic [PLUG_W-1:0] plug,
	input  logic [CUR_W-1:0]  current,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [CUR_W-1:0]  qualified_current,
	output logic              is_stable
);

	localparam int PIW    = (PLUGS > 1) ? $clog2(PLUGS) : 1;
	localparam int SW     = $clog2(SAMPLES);
	localparam int FCW    = $clog2(SAMPLES + 1);
	localparam int SUMW   = CUR_W + $clog2(SAMPLES);
	localparam int DEPTH  = PLUGS * SAMPLES;
	localparam int AW     = $clog2(DEPTH);
	localparam int SHIFT  = SUMW + $clog2(SAMPLES);
	localparam int MULW   = SUMW + 2;
	localparam int PRODW  = SUMW + MULW;
	localparam logic [MULW-1:0] RECIP =
		MULW'((64'd1 << SHIFT) / SAMPLES + 64'd1);

	// configuration
	cur_t threshold_q;
	cnt_t stable_q;
	cnt_t penalty_q;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			stable_q    <= STABLE_COUNT_RST;
			penalty_q   <= PENALTY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_THRESHOLD:    threshold_q <= pwdata[CUR_W-1:0];
				REG_STABLE_COUNT: stable_q    <= pwdata[CNT_W-1:0];
				REG_PENALTY:      penalty_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_THRESHOLD:    prdata = DATA_W'(threshold_q);
			REG_STABLE_COUNT: prdata = DATA_W'(stable_q);
			REG_PENALTY:      prdata = DATA_W'(penalty_q);
			default:          prdata = '0;
		endcase
	end

	// per-plug state
	logic [SUMW-1:0]  sum_q   [PLUGS];
	logic [SW-1:0]    slot_q  [PLUGS];
	cnt_t             cnt_q   [PLUGS];
	cur_t             fillv_q [PLUGS];
	logic [FCW-1:0]   fillc_q [PLUGS];

	cur_t ring_mem [DEPTH];

	// working stage
	logic             s1_valid_q;
	logic             action_s1;
	logic             plug_ok_s1;
	logic [PIW-1:0]   plug_s1;
	cur_t             cur_s1;
	logic [AW-1:0]    addr_s1;
	cur_t             rd_s1;

	logic             result_valid_q;
	cur_t             qualified_current_q;
	logic             is_stable_q;

	logic             s1_adv;
	logic             accept;
	logic             s1_fire;
	logic [PIW-1:0]   plug_in;
	logic             plug_ok_in;
	logic [SW-1:0]    slot_rd;
	logic [AW-1:0]    addr_in;

	logic [SUMW-1:0]  sum_cur;
	logic [SW-1:0]    slot_cur;
	cnt_t             cnt_cur;
	cur_t             fillv_cur;
	logic [FCW-1:0]   fillc_cur;
	logic [PRODW-1:0] prod;
	cur_t             mean;
	cur_t             diff;
	logic             deviate;
	cur_t             oldest;
	logic [CNT_W:0]   cnt_inc;
	cnt_t             cnt_new;
	logic [SUMW-1:0]  sum_new;
	logic [SW-1:0]    slot_new;
	logic [FCW-1:0]   fillc_new;
	logic             do_sample;
	logic             do_fill;
	cur_t             q_new;
	logic             stable_new;

	assign s1_adv       = !result_valid_q || result_ready;
	assign sample_ready = !s1_valid_q || s1_adv;
	assign accept       = sample_valid && sample_ready;
	assign s1_fire      = s1_valid_q && s1_adv;

	assign plug_in    = PIW'(plug);
	assign plug_ok_in = (7'(plug) < 7'(PLUGS));

	assign sum_cur   = sum_q[plug_s1];
	assign slot_cur  = slot_q[plug_s1];
	assign cnt_cur   = cnt_q[plug_s1];
	assign fillv_cur = fillv_q[plug_s1];
	assign fillc_cur = fillc_q[plug_s1];

	assign do_sample = plug_ok_s1 && (action_s1 == ACT_SAMPLE);
	assign do_fill   = plug_ok_s1 && (action_s1 == ACT_FILL);

	// mean = floor(sum / SAMPLES) through an exact reciprocal
	assign prod = PRODW'(sum_cur) * PRODW'(RECIP);
	assign mean = prod[SHIFT +: CUR_W];
	assign diff = (cur_s1 > mean) ? cur_s1 - mean : mean - cur_s1;
	assign deviate = diff > threshold_q;

	// slots at or past the fill count still hold the fill value
	assign oldest  = (FCW'(slot_cur) < fillc_cur) ? rd_s1 : fillv_cur;
	assign sum_new = sum_cur - SUMW'(oldest) + SUMW'(cur_s1);
	assign slot_new = (32'(slot_cur) == SAMPLES - 1) ? '0 : slot_cur + 1'b1;
	assign fillc_new = (32'(fillc_cur) >= SAMPLES) ? fillc_cur : fillc_cur + 1'b1;

	assign cnt_inc = {1'b0, cnt_cur} + 1'b1;

	always_comb begin
		if (deviate) begin
			cnt_new = (cnt_cur > penalty_q) ? cnt_cur - penalty_q : '0;
		end else if (cnt_inc >= {1'b0, stable_q}) begin
			cnt_new = stable_q;
		end else begin
			cnt_new = cnt_inc[CNT_W-1:0];
		end
	end

	always_comb begin
		q_new      = '0;
		stable_new = 1'b0;
		if (do_sample) begin
			priority if (cnt_new == '0) begin
				q_new = '0;
			end else if (cnt_new == stable_q) begin
				q_new      = mean;
				stable_new = 1'b1;
			end else begin
				q_new = cur_s1;
			end
		end
	end

	// forward the slot that the working stage leaves for the same plug
	always_comb begin
		slot_rd = slot_q[plug_in];
		if (s1_fire && plug_ok_s1 && plug_s1 == plug_in) begin
			priority if (do_fill) begin
				slot_rd = '0;
			end else if (deviate) begin
				slot_rd = slot_new;
			end else begin
				slot_rd = slot_cur;
			end
		end
	end

	assign addr_in = AW'(plug_in) * AW'(SAMPLES) + AW'(slot_rd);

	always_ff @(posedge clk) begin
		if (s1_fire && do_sample && deviate) begin
			ring_mem[addr_s1] <= cur_s1;
		end
		if (accept) begin
			rd_s1 <= ring_mem[addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			plug_s1    <= plug_in;
			plug_ok_s1 <= plug_ok_in;
			cur_s1     <= current;
			addr_s1    <= addr_in;
		end
		if (s1_fire) begin
			qualified_current_q <= q_new;
			is_stable_q         <= stable_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				s1_valid_q <= sample_valid;
			end
			if (s1_adv) begin
				result_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLUGS; p++) begin
				sum_q[p]   <= '0;
				slot_q[p]  <= '0;
				cnt_q[p]   <= '0;
				fillv_q[p] <= '0;
				fillc_q[p] <= '0;
			end
		end else if (s1_fire) begin
			if (do_fill) begin
				sum_q[plug_s1]   <= SUMW'(cur_s1) * SUMW'(SAMPLES);
				slot_q[plug_s1]  <= '0;
				cnt_q[plug_s1]   <= '0;
				fillv_q[plug_s1] <= cur_s1;
				fillc_q[plug_s1] <= '0;
			end else if (do_sample) begin
				cnt_q[plug_s1] <= cnt_new;
				if (deviate) begin
					sum_q[plug_s1]   <= sum_new;
					slot_q[plug_s1]  <= slot_new;
					fillc_q[plug_s1] <= fillc_new;
				end
			end
		end
	end

	assign result_valid      = result_valid_q;
	assign qualified_current = qualified_current_q;
	assign is_stable         = is_stable_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (s1_valid_q && result_valid_q && !result_ready))
		else $error("input stalled without a held result");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> result_valid_q)
		else $error("advanced transaction produced no result");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && plug_ok_s1) |-> (32'(fillc_cur) <= SAMPLES))
		else $error("fill count beyond ring depth");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && plug_ok_s1) |-> (32'(slot_cur) < SAMPLES))
		else $error("write slot beyond ring depth");

	a_stable_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && stable_new) |=> is_stable && result_valid)
		else $error("stable result lost");

endmodule
